@@ hw/rtl/hnsf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the held-note spacing filter: item types, operation codes and sizes.
// Used by every module of the block; depends on nothing else.
package hnsf_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HELD_W      = 6;
    localparam int SPACING_W   = 4;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 4'd3;

    localparam int PITCH_W     = 7;
    localparam int PITCH_COUNT = 128;
    localparam int CHUNK_W     = 8;
    localparam int NUM_CHUNKS  = PITCH_COUNT / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int CHUNK_POS_W = $clog2(CHUNK_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_LOCAL    = 2'd0;
    localparam logic [1:0] FUNC_EXTERNAL = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_PLAY   = 3'd1,
        OP_REMOVE = 3'd2,
        OP_RECORD = 3'd3,
        OP_CLEAR  = 3'd4
    } op_kind_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         device_id;
        logic [PITCH_W-1:0] pitch;
        logic [6:0]         velocity;
    } in_item_t;

    typedef struct packed {
        logic               played;
        logic               reassigned;
        logic [7:0]         out_device;
        logic [PITCH_W-1:0] out_pitch;
        logic [6:0]         out_velocity;
        logic               dropped;
        logic               table_full;
        logic [HELD_W-1:0]  held_count;
    } out_item_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [7:0]         device_id;
        logic [PITCH_W-1:0] pitch;
        logic [6:0]         velocity;
    } op_t;

endpackage

@@ hw/rtl/held_note_spacing_filter_unit.sv @@
`timescale 1ns / 1ps
// Held-note spacing filter top level: front end, operation queue and table engine.
// A local note-on first reads one table entry per cycle to mark close pitches, then tests one
// eight-pitch group per cycle in the search. A note-off scans one table entry per cycle.
// The table engine takes a new transaction only when it is through with the last one;
// a two-entry queue absorbs input bursts.
// Reset empties the table and sets spacing to 3. Depends on hnsf_pkg.
module held_note_spacing_filter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  hnsf_pkg::in_item_t             item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output hnsf_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hnsf_pkg::SPACING_W-1:0] cfg_spacing
);
    import hnsf_pkg::*;

    logic                 spacing_reg_en;
    logic [SPACING_W-1:0] spacing_reg;
    logic                 queue_full;
    logic                 push;
    op_t                  push_op;
    logic                 head_valid;
    op_t                  head_op;
    logic                 pop;

    assign cfg_ready      = 1'b1;
    assign spacing_reg_en = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
        end
        else if (spacing_reg_en)
        begin
            spacing_reg <= cfg_spacing;
        end
    end

    hnsf_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .op         (push_op)
    );

    hnsf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .valid   (head_valid),
        .head_op (head_op),
        .pop     (pop)
    );

    hnsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (head_valid),
        .op           (head_op),
        .op_pop       (pop),
        .spacing      (spacing_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ hw/rtl/hnsf_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input transactions and classifies them into table operations.
// Depends on hnsf_pkg.
module hnsf_front (
    input  logic              item_valid,
    output logic              item_ready,
    input  hnsf_pkg::in_item_t item,
    input  logic              queue_full,
    output logic              push,
    output hnsf_pkg::op_t     op
);
    import hnsf_pkg::*;

    assign item_ready = !queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        op.device_id = item.device_id;
        op.pitch     = item.pitch;
        op.velocity  = item.velocity;
        unique case (item.func)
            FUNC_LOCAL:    op.kind = (item.velocity == '0) ? OP_REMOVE : OP_PLAY;
            FUNC_EXTERNAL: op.kind = (item.velocity == '0) ? OP_REMOVE : OP_RECORD;
            FUNC_CLEAR:    op.kind = OP_CLEAR;
            default:       op.kind = OP_NONE;
        endcase
    end

endmodule

@@ hw/rtl/hnsf_queue.sv @@
`timescale 1ns / 1ps
// Short operation queue between the front end and the table engine.
// Depends on hnsf_pkg.
module hnsf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hnsf_pkg::op_t push_op,
    output logic          full,
    output logic          valid,
    output hnsf_pkg::op_t head_op,
    input  logic          pop
);
    import hnsf_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ hw/rtl/hnsf_back.sv @@
`timescale 1ns / 1ps
// Table engine: holds the pitch table, runs spacing searches and removals, and
// drives the registered result channel. Depends on hnsf_pkg.
module hnsf_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             op_valid,
    input  hnsf_pkg::op_t                    op,
    output logic                             op_pop,
    input  logic [hnsf_pkg::SPACING_W-1:0]   spacing,
    output logic                             result_valid,
    input  logic                             result_ready,
    output hnsf_pkg::out_item_t              result
);
    import hnsf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_REMOVE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    op_t                     op_reg;
    op_t                     op_next;
    logic [CNT_W-1:0]        scan_reg;
    logic [CNT_W-1:0]        scan_next;
    logic                    found_reg;
    logic                    found_next;
    logic [PITCH_COUNT-1:0]  blocked_reg;
    logic [PITCH_COUNT-1:0]  blocked_next;
    logic [CHUNK_IDX_W-1:0]  chunk_reg;
    logic [CHUNK_IDX_W-1:0]  chunk_next;
    out_item_t               res_reg;
    out_item_t               res_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    out_item_t               out_reg;
    out_item_t               out_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [PITCH_W-1:0]      held_reg [TABLE_DEPTH];

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [PITCH_W-1:0]      wr_data;
    logic [IDX_W-1:0]        scan_idx;
    logic [PITCH_W-1:0]      rd_pitch;
    logic [PITCH_COUNT-1:0]  near_mask;
    logic [CHUNK_W-1:0]      free_bits;
    logic                    hit;
    logic [CHUNK_POS_W-1:0]  hit_pos;
    logic [PITCH_W-1:0]      cand;
    logic                    has_room;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign scan_idx     = scan_reg[IDX_W-1:0];
    assign rd_pitch     = held_reg[scan_idx];
    assign has_room     = (count_reg < CNT_W'(TABLE_DEPTH));
    assign cand         = {chunk_reg, hit_pos};

    always_comb
    begin
        logic [PITCH_W-1:0] pv;
        logic [PITCH_W-1:0] gap;
        for (int p = 0; p < PITCH_COUNT; p++)
        begin
            pv   = PITCH_W'(p);
            gap  = (pv > rd_pitch) ? pv - rd_pitch : rd_pitch - pv;
            near_mask[p] = (gap != '0) && (gap < PITCH_W'(spacing));
        end
    end

    always_comb
    begin
        logic [PITCH_W-1:0] idx;
        for (int j = 0; j < CHUNK_W; j++)
        begin
            idx          = {chunk_reg, CHUNK_POS_W'(j)};
            free_bits[j] = !blocked_reg[idx] && (idx >= op_reg.pitch);
        end
        hit     = (free_bits != '0);
        hit_pos = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                hit_pos = CHUNK_POS_W'(j);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        blocked_next   = blocked_reg;
        chunk_next     = chunk_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        op_pop         = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = op_reg.pitch;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop       = 1'b1;
                    op_next      = op;
                    res_next     = '0;
                    scan_next    = '0;
                    found_next   = 1'b0;
                    blocked_next = '0;
                    chunk_next   = op.pitch[PITCH_W-1:CHUNK_POS_W];
                    unique case (op.kind)
                        OP_PLAY:   state_next = S_SCAN;
                        OP_REMOVE: state_next = S_REMOVE;
                        OP_RECORD:
                        begin
                            if (has_room)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = op.pitch;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.table_full = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    blocked_next = blocked_reg | near_mask;
                    scan_next    = scan_reg + 1'b1;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    res_next.played       = 1'b1;
                    res_next.reassigned   = (cand != op_reg.pitch);
                    res_next.out_device   = op_reg.device_id;
                    res_next.out_pitch    = cand;
                    res_next.out_velocity = op_reg.velocity;
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = cand;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_next.table_full = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (chunk_reg == CHUNK_IDX_W'(NUM_CHUNKS - 1))
                begin
                    res_next.dropped = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            S_REMOVE:
            begin
                if (scan_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = scan_idx - 1'b1;
                        wr_data = rd_pitch;
                    end
                    else if (rd_pitch == op_reg.pitch)
                    begin
                        found_next = 1'b1;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next            = res_reg;
                    out_next.held_count = HELD_W'(count_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        scan_reg    <= scan_next;
        found_reg   <= found_next;
        blocked_reg <= blocked_next;
        chunk_reg   <= chunk_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        if (wr_en)
        begin
            held_reg[wr_addr] <= wr_data;
        end
    end

endmodule

@@ test/tb_held_note_spacing_filter_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for held_note_spacing_filter_unit: directed rows, then random phases
// at several spacings, checked against a behavioral table model. Depends on hnsf_pkg.
module tb_held_note_spacing_filter_unit;
    import hnsf_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 1200;
    localparam int         QUIET_ITEMS  = 150;
    localparam int         HOLD_AT      = 300;
    localparam int         LONG_HOLD    = 400;
    localparam int         DRAIN_CYCLES = 60;
    localparam int         CYCLE_LIMIT  = 600000;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } note_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    in_item_t             item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    out_item_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SPACING_W-1:0] cfg_spacing = '0;

    logic [PITCH_W-1:0]   held_tab [TABLE_DEPTH];
    int                   held_n = 0;
    int                   spacing_now = SPACING_RESET;
    out_item_t            pending_outcomes [$];
    note_row_t            note_rows [$];
    int                   outcomes_seen = 0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   notes_counted = 0;
    bit                   quiet = 1'b0;
    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    bit                   long_hold_done = 1'b0;

    held_note_spacing_filter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_spacing  (cfg_spacing)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void add_row(in_item_t stim, bit typed, out_item_t want);
        note_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        note_rows = {note_rows, row};
    endfunction

    function automatic bit crowds_held(int cand);
        int d;
        for (int i = 0; i < held_n; i++)
        begin
            d = cand - int'(held_tab[i]);
            if (d < 0)
                d = -d;
            if (d > 0 && d < spacing_now)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void release_pitch(logic [PITCH_W-1:0] p);
        for (int i = 0; i < held_n; i++)
        begin
            if (held_tab[i] == p)
            begin
                for (int j = i; j + 1 < held_n; j++)
                    held_tab[j] = held_tab[j + 1];
                held_n--;
                return;
            end
        end
    endfunction

    function automatic bit hold_pitch(logic [PITCH_W-1:0] p);
        if (held_n >= TABLE_DEPTH)
            return 1'b0;
        held_tab[held_n] = p;
        held_n++;
        return 1'b1;
    endfunction

    function automatic out_item_t spaced_outcome(in_item_t x);
        out_item_t r;
        int        cand;
        r = '0;
        case (x.func)
            FUNC_LOCAL:
            begin
                if (x.velocity == 0)
                    release_pitch(x.pitch);
                else
                begin
                    cand = x.pitch;
                    while (cand < PITCH_COUNT && crowds_held(cand))
                        cand++;
                    if (cand >= PITCH_COUNT)
                        r.dropped = 1'b1;
                    else
                    begin
                        r.played       = 1'b1;
                        r.reassigned   = (cand != int'(x.pitch));
                        r.out_device   = x.device_id;
                        r.out_pitch    = PITCH_W'(cand);
                        r.out_velocity = x.velocity;
                        r.table_full   = !hold_pitch(PITCH_W'(cand));
                    end
                end
            end
            FUNC_EXTERNAL:
            begin
                if (x.velocity == 0)
                    release_pitch(x.pitch);
                else
                    r.table_full = !hold_pitch(x.pitch);
            end
            FUNC_CLEAR:
                held_n = 0;
            default: ;
        endcase
        r.held_count = HELD_W'(held_n);
        return r;
    endfunction

    task automatic send_note(in_item_t x, bit typed, out_item_t want);
        out_item_t predicted;
        item       <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predicted = spaced_outcome(x);
        pending_outcomes = {pending_outcomes, (typed ? want : predicted)};
        if (tx_idle_on && !quiet && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_spacing(logic [SPACING_W-1:0] s);
        cfg_spacing <= s;
        cfg_valid   <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        spacing_now = s;
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_note(int on_weight);
        in_item_t x;
        int       pick;
        x.device_id = 8'($urandom_range(0, 255));
        x.velocity  = 7'($urandom_range(1, 127));
        pick = $urandom_range(0, 99);
        if (pick < on_weight)
        begin
            x.func = ($urandom_range(0, 9) < 7) ? FUNC_LOCAL : FUNC_EXTERNAL;
            if ($urandom_range(0, 5) == 0)
                x.pitch = 7'($urandom_range(108, 127));
            else if ($urandom_range(0, 2) == 0)
                x.pitch = 7'($urandom_range(0, 127));
            else
                x.pitch = 7'($urandom_range(48, 84));
        end
        else if (pick < 93)
        begin
            x.func     = $urandom_range(0, 1) ? FUNC_LOCAL : FUNC_EXTERNAL;
            x.velocity = '0;
            if (held_n > 0 && $urandom_range(0, 3) != 0)
                x.pitch = held_tab[$urandom_range(0, held_n - 1)];
            else
                x.pitch = 7'($urandom_range(0, 127));
        end
        else if (pick < 96)
        begin
            x.func  = FUNC_CLEAR;
            x.pitch = 7'($urandom_range(0, 127));
        end
        else
        begin
            x.func     = 2'($urandom_range(0, 3));
            x.pitch    = 7'($urandom_range(0, 127));
            x.velocity = 7'($urandom_range(0, 127));
        end
        return x;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            outcomes_seen <= outcomes_seen + 1;
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: %p", result);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result.played !== want.played || result.reassigned !== want.reassigned
                    || result.out_device !== want.out_device
                    || result.out_pitch !== want.out_pitch
                    || result.out_velocity !== want.out_velocity
                    || result.dropped !== want.dropped
                    || result.table_full !== want.table_full
                    || result.held_count !== want.held_count)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("Result %0d mismatch: expected %p, got %p",
                                 outcomes_seen, want, result);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && outcomes_seen >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_idle_on && !quiet && $urandom_range(0, 9) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    initial
    begin
        in_item_t x;
        int       phase_len;
        int       on_weight;
        int       phase;

        add_row(in_item_t'{FUNC_LOCAL, 8'hA5, 7'd60, 7'd100}, 1'b1,
                out_item_t'{1'b1, 1'b0, 8'hA5, 7'd60, 7'd100, 1'b0, 1'b0, 6'd1});
        add_row(in_item_t'{FUNC_LOCAL, 8'h5A, 7'd61, 7'd127}, 1'b0, '0);
        add_row(in_item_t'{FUNC_LOCAL, 8'hFF, 7'd0, 7'd1}, 1'b1,
                out_item_t'{1'b1, 1'b0, 8'hFF, 7'd0, 7'd1, 1'b0, 1'b0, 6'd3});
        add_row(in_item_t'{FUNC_EXTERNAL, 8'h00, 7'd127, 7'd127}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd4});
        add_row(in_item_t'{FUNC_EXTERNAL, 8'h11, 7'd125, 7'd64}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd5});
        add_row(in_item_t'{FUNC_LOCAL, 8'h22, 7'd124, 7'd10}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b1, 1'b0, 6'd5});
        add_row(in_item_t'{FUNC_LOCAL, 8'h00, 7'd63, 7'd0}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd4});
        add_row(in_item_t'{FUNC_EXTERNAL, 8'h00, 7'd50, 7'd0}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd4});
        add_row(in_item_t'{FUNC_UNUSED, 8'hFF, 7'd127, 7'd127}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd4});
        add_row(in_item_t'{FUNC_LOCAL, 8'h33, 7'd62, 7'd55}, 1'b0, '0);
        add_row(in_item_t'{FUNC_EXTERNAL, 8'h00, 7'd127, 7'd0}, 1'b0, '0);
        add_row(in_item_t'{FUNC_LOCAL, 8'h44, 7'd126, 7'd1}, 1'b0, '0);
        add_row(in_item_t'{FUNC_CLEAR, 8'hFF, 7'd127, 7'd127}, 1'b1,
                out_item_t'{1'b0, 1'b0, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0});
        add_row(in_item_t'{FUNC_EXTERNAL, 8'h00, 7'd40, 7'd20}, 1'b0, '0);
        add_row(in_item_t'{FUNC_LOCAL, 8'h80, 7'd40, 7'd127}, 1'b0, '0);
        add_row(in_item_t'{FUNC_LOCAL, 8'h00, 7'd40, 7'd0}, 1'b0, '0);
        add_row(in_item_t'{FUNC_EXTERNAL, 8'h00, 7'd40, 7'd0}, 1'b0, '0);
        add_row(in_item_t'{FUNC_LOCAL, 8'h7F, 7'd127, 7'd127}, 1'b1,
                out_item_t'{1'b1, 1'b0, 8'h7F, 7'd127, 7'd127, 1'b0, 1'b0, 6'd1});
        add_row(in_item_t'{FUNC_LOCAL, 8'h01, 7'd126, 7'd2}, 1'b0, '0);
        add_row(in_item_t'{FUNC_CLEAR, 8'h00, 7'd0, 7'd0}, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (note_rows[i])
            send_note(note_rows[i].stim, note_rows[i].typed, note_rows[i].want);

        phase = 0;
        while (notes_counted < RANDOM_ITEMS)
        begin
            settle();
            if (phase == 0)
                write_spacing(4'd12);
            else if (phase == 1)
                write_spacing(4'd1);
            else
                write_spacing(SPACING_W'($urandom_range(1, 12)));
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            on_weight  = ($urandom_range(0, 2) == 0) ? 85 : 55;
            phase_len  = $urandom_range(60, 160);
            for (int n = 0; n < phase_len && notes_counted < RANDOM_ITEMS; n++)
            begin
                x = random_note(on_weight);
                if (x.func != FUNC_UNUSED)
                    notes_counted++;
                if (notes_counted > RANDOM_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
                send_note(x, 1'b0, '0);
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/hnsf_pkg.sv
hw/rtl/hnsf_front.sv
hw/rtl/hnsf_queue.sv
hw/rtl/hnsf_back.sv
hw/rtl/held_note_spacing_filter_unit.sv
test/tb_held_note_spacing_filter_unit.sv
